[sv/nps_pkg.sv]
package nps_pkg;

    // Job table size and derived index widths
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Field widths
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int ID_W   = 5;
    localparam int TIME_W = 21;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // One job table entry
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [PRI_W-1:0] prio;
    } t_entry;

    // Write port of the job table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_tbl_wr;

endpackage

[sv/nps_job_if.sv]
interface nps_job_if;
    logic                     valid;
    logic                     ready;
    logic [nps_pkg::ARR_W-1:0] arrival_time;
    logic [nps_pkg::BUR_W-1:0] burst_time;
    logic [nps_pkg::PRI_W-1:0] priority_level;
    logic                     last_process;

    modport source (
        output valid, arrival_time, burst_time, priority_level, last_process,
        input  ready
    );
    modport sink (
        input  valid, arrival_time, burst_time, priority_level, last_process,
        output ready
    );
endinterface

[sv/nps_res_if.sv]
interface nps_res_if;
    logic                      valid;
    logic                      ready;
    logic [nps_pkg::ID_W-1:0]   process_id;
    logic [nps_pkg::TIME_W-1:0] completion_time;
    logic [nps_pkg::TIME_W-1:0] turnaround_time;
    logic [nps_pkg::TIME_W-1:0] waiting_time;
    logic                      last_result;

    modport source (
        output valid, process_id, completion_time, turnaround_time, waiting_time,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, process_id, completion_time, turnaround_time, waiting_time,
               last_result,
        output ready
    );
endinterface

[sv/nps_tbl.sv]
module nps_tbl (
    input  logic                    i_clk,
    input  nps_pkg::t_tbl_wr        i_wr,
    input  logic [nps_pkg::IDX_W-1:0] i_rd_addr,
    output nps_pkg::t_entry         o_rd_data
);

    nps_pkg::t_entry mem [nps_pkg::MAX_PROCS];
    nps_pkg::t_entry r_rd_data;

    // Write one entry per beat
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/nonpreemptive_priority_scheduler_top.sv]
// Load: one job per cycle while loading; a beat with last_process set starts the schedule.
// Schedule: each decision scans the job table through its registered read port, then
// takes a decide step and an emit step; where no stored job has arrived yet, time jumps
// ahead to the earliest pending arrival and the table is scanned again.
// Input is stalled while a set is scheduled; results leave through an output register.
// Reset (synchronous, active low) clears control state; table contents are not cleared.
module nonpreemptive_priority_scheduler_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nps_job_if.sink    i_job,
    nps_res_if.source  o_res
);

    nps_pkg::t_state                 r_state, n_state;
    logic [nps_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [nps_pkg::CNT_W-1:0]       r_done, n_done;
    logic [nps_pkg::TIME_W-1:0]      r_time, n_time;
    logic [nps_pkg::MAX_PROCS-1:0]   r_fin, n_fin;
    logic [nps_pkg::CNT_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic                            r_rd_vld, n_rd_vld;
    logic [nps_pkg::IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                            r_found, n_found;
    logic                            r_any, n_any;
    logic [nps_pkg::IDX_W-1:0]       r_pick, n_pick;
    logic [nps_pkg::PRI_W-1:0]       r_pick_pri, n_pick_pri;
    logic [nps_pkg::ARR_W-1:0]       r_pick_arr, n_pick_arr;
    logic [nps_pkg::BUR_W-1:0]       r_pick_bur, n_pick_bur;
    logic [nps_pkg::ARR_W-1:0]       r_next_arr, n_next_arr;
    logic [nps_pkg::TIME_W-1:0]      r_wait, n_wait;

    logic                            r_out_vld;
    logic [nps_pkg::ID_W-1:0]        r_out_id;
    logic [nps_pkg::TIME_W-1:0]      r_out_cmp;
    logic [nps_pkg::TIME_W-1:0]      r_out_tat;
    logic [nps_pkg::TIME_W-1:0]      r_out_wait;
    logic                            r_out_last;

    nps_pkg::t_tbl_wr                tbl_wr;
    nps_pkg::t_entry                 rd_data;
    logic                            in_beat;
    logic                            rd_issue;
    logic                            scan_end;
    logic                            emit_go;
    logic                            emit_last;
    logic [nps_pkg::TIME_W-1:0]      arr_ext;

    // Job table
    nps_tbl u_tbl (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_rd_ptr[nps_pkg::IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Handshake and phase conditions
    assign i_job.ready = (r_state == nps_pkg::ST_LOAD);
    assign in_beat     = i_job.valid && i_job.ready;
    assign rd_issue    = (r_state == nps_pkg::ST_SCAN) && (r_rd_ptr != r_cnt);
    assign scan_end    = (r_rd_ptr == r_cnt) && !r_rd_vld;
    assign emit_go     = (r_state == nps_pkg::ST_EMIT) && (!r_out_vld || o_res.ready);
    assign emit_last   = ((r_done + nps_pkg::CNT_W'(1)) == r_cnt);
    assign arr_ext     = nps_pkg::TIME_W'(rd_data.arrival);

    // Store a job while the table has room
    always_comb begin
        tbl_wr.en         = in_beat && (r_cnt < nps_pkg::CNT_W'(nps_pkg::MAX_PROCS));
        tbl_wr.addr       = r_cnt[nps_pkg::IDX_W-1:0];
        tbl_wr.data.arrival = i_job.arrival_time;
        tbl_wr.data.burst   = i_job.burst_time;
        tbl_wr.data.prio    = i_job.priority_level;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nps_pkg::ST_LOAD: begin
                if (in_beat && i_job.last_process) begin
                    n_state = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = nps_pkg::ST_DECIDE;
                end
            end
            nps_pkg::ST_DECIDE: begin
                n_state = r_found ? nps_pkg::ST_EMIT : nps_pkg::ST_SCAN;
            end
            nps_pkg::ST_EMIT: begin
                if (emit_go) begin
                    n_state = emit_last ? nps_pkg::ST_LOAD : nps_pkg::ST_SCAN;
                end
            end
            default: n_state = nps_pkg::ST_LOAD;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_cnt      = r_cnt;
        n_done     = r_done;
        n_time     = r_time;
        n_fin      = r_fin;
        n_rd_ptr   = r_rd_ptr;
        n_rd_vld   = rd_issue;
        n_rd_idx   = r_rd_ptr[nps_pkg::IDX_W-1:0];
        n_found    = r_found;
        n_any      = r_any;
        n_pick     = r_pick;
        n_pick_pri = r_pick_pri;
        n_pick_arr = r_pick_arr;
        n_pick_bur = r_pick_bur;
        n_next_arr = r_next_arr;
        n_wait     = r_wait;

        case (r_state)
            nps_pkg::ST_LOAD: begin
                if (tbl_wr.en) begin
                    n_cnt = r_cnt + nps_pkg::CNT_W'(1);
                end
                n_rd_ptr = '0;
                n_found  = 1'b0;
                n_any    = 1'b0;
            end
            nps_pkg::ST_SCAN: begin
                if (rd_issue) begin
                    n_rd_ptr = r_rd_ptr + nps_pkg::CNT_W'(1);
                end
                // Fold one returned entry into the running minimums
                if (r_rd_vld && !r_fin[r_rd_idx]) begin
                    n_any = 1'b1;
                    if (!r_any || (rd_data.arrival < r_next_arr)) begin
                        n_next_arr = rd_data.arrival;
                    end
                    if ((arr_ext <= r_time) && (!r_found || (rd_data.prio < r_pick_pri))) begin
                        n_found    = 1'b1;
                        n_pick     = r_rd_idx;
                        n_pick_pri = rd_data.prio;
                        n_pick_arr = rd_data.arrival;
                        n_pick_bur = rd_data.burst;
                    end
                end
            end
            nps_pkg::ST_DECIDE: begin
                if (r_found) begin
                    // Start time minus arrival is the waiting time
                    n_wait = r_time - nps_pkg::TIME_W'(r_pick_arr);
                    n_time = r_time + nps_pkg::TIME_W'(r_pick_bur);
                end else begin
                    // Idle: jump to the earliest pending arrival and rescan
                    n_time = nps_pkg::TIME_W'(r_next_arr);
                end
                n_rd_ptr = '0;
                n_found  = 1'b0;
                n_any    = 1'b0;
            end
            nps_pkg::ST_EMIT: begin
                if (emit_go) begin
                    if (emit_last) begin
                        n_cnt  = '0;
                        n_done = '0;
                        n_time = '0;
                        n_fin  = '0;
                    end else begin
                        n_done        = r_done + nps_pkg::CNT_W'(1);
                        n_fin[r_pick] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nps_pkg::ST_LOAD;
            r_cnt    <= '0;
            r_done   <= '0;
            r_time   <= '0;
            r_fin    <= '0;
            r_rd_ptr <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_done   <= n_done;
            r_time   <= n_time;
            r_fin    <= n_fin;
            r_rd_ptr <= n_rd_ptr;
            r_rd_vld <= n_rd_vld;
            r_found  <= n_found;
            r_any    <= n_any;
        end
    end

    // Scan payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_pick     <= n_pick;
        r_pick_pri <= n_pick_pri;
        r_pick_arr <= n_pick_arr;
        r_pick_bur <= n_pick_bur;
        r_next_arr <= n_next_arr;
        r_wait     <= n_wait;
    end

    // Output register: load on emit, drop after the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_go) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_id   <= nps_pkg::ID_W'(r_pick) + nps_pkg::ID_W'(1);
            r_out_cmp  <= r_time;
            r_out_tat  <= r_time - nps_pkg::TIME_W'(r_pick_arr);
            r_out_wait <= r_wait;
            r_out_last <= emit_last;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.process_id      = r_out_id;
    assign o_res.completion_time = r_out_cmp;
    assign o_res.turnaround_time = r_out_tat;
    assign o_res.waiting_time    = r_out_wait;
    assign o_res.last_result     = r_out_last;

    // Finished flags track the number of results sent in this set
    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_fin) == int'(r_done))
        else $error("finished flags disagree with result count");

    // A scheduling pass never runs past the stored set
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nps_pkg::ST_LOAD) |-> (r_done < r_cnt))
        else $error("result count reached job count while scheduling");

    // The chosen job has not run yet
    a_pick_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nps_pkg::ST_EMIT) |-> !r_fin[r_pick])
        else $error("picked a finished job");

    // The final result of a set returns the block to loading
    a_set_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && emit_last) |=> (r_state == nps_pkg::ST_LOAD) && (r_cnt == '0))
        else $error("set did not close after its last result");

endmodule

[tb/nps_sched_checker.sv]
module nps_sched_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nps_job_if   i_job,
    nps_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import nps_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] done_at;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last;
    } t_sched_res;

    // Shadow job table, filled in load order
    logic [ARR_W-1:0] job_arrival [MAX_PROCS];
    logic [BUR_W-1:0] job_burst   [MAX_PROCS];
    logic [PRI_W-1:0] job_prio    [MAX_PROCS];
    int               job_cnt = 0;

    // Results still owed by the block, in schedule order
    t_sched_res sched_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Run the whole set to completion and queue one result per job
    function automatic void plan_schedule();
        logic [MAX_PROCS-1:0] finished;
        longint unsigned      now;
        longint unsigned      earliest;
        longint unsigned      turn;
        int                   pick;
        int                   issued;
        bit                   waiting_jobs;
        t_sched_res           r;
        finished = '0;
        now      = 0;
        issued   = 0;
        while (issued < job_cnt) begin
            pick         = -1;
            waiting_jobs = 1'b0;
            earliest     = 0;
            for (int k = 0; k < job_cnt; k++) begin
                if (!finished[k]) begin
                    if (!waiting_jobs || job_arrival[k] < earliest)
                        earliest = job_arrival[k];
                    waiting_jobs = 1'b1;
                    // strict compare keeps the lower job number on a tie
                    if (job_arrival[k] <= now &&
                        (pick < 0 || job_prio[k] < job_prio[pick]))
                        pick = k;
                end
            end
            if (pick < 0) begin
                // nothing ready: jump to the next arrival
                now = earliest;
            end else begin
                now          = now + job_burst[pick];
                turn         = now - job_arrival[pick];
                r.id         = ID_W'(pick + 1);
                r.done_at    = TIME_W'(now);
                r.turnaround = TIME_W'(turn);
                r.waiting    = TIME_W'(turn - job_burst[pick]);
                r.last       = (issued + 1 == job_cnt);
                sched_q.push_back(r);
                finished[pick] = 1'b1;
                issued++;
            end
        end
    endfunction

    task automatic check_field(input string name, input longint unsigned want_v,
                               input longint unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    // Watch both channels on every rising edge
    always @(posedge i_clk) begin
        t_sched_res got;
        t_sched_res want;
        if (i_rst_n) begin
            // compare a result beat against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.process_id, i_res.completion_time, i_res.turnaround_time,
                        i_res.waiting_time, i_res.last_result};
                if (sched_q.size() == 0) begin
                    $error("unexpected result beat: process_id %0d", got.id);
                    o_fail_count++;
                end else begin
                    want = sched_q.pop_front();
                    check_field("process_id", want.id, got.id);
                    check_field("completion_time", want.done_at, got.done_at);
                    check_field("turnaround_time", want.turnaround, got.turnaround);
                    check_field("waiting_time", want.waiting, got.waiting);
                    check_field("last_result", want.last, got.last);
                end
            end

            // store a job beat; drop it when the table is full
            if (i_job.valid && i_job.ready) begin
                if (job_cnt < MAX_PROCS) begin
                    job_arrival[job_cnt] = i_job.arrival_time;
                    job_burst[job_cnt]   = i_job.burst_time;
                    job_prio[job_cnt]    = i_job.priority_level;
                    job_cnt++;
                end
                if (i_job.last_process) begin
                    plan_schedule();
                    job_cnt = 0;
                end
            end
            o_pending = sched_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    import nps_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TOTAL_ITEMS  = 100;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   idle_cycles = 0;
    int   items_sent  = 0;
    bit   steady      = 1'b0;

    nps_job_if job_ch ();
    nps_res_if res_ch ();

    nonpreemptive_priority_scheduler_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_job   (job_ch),
        .o_res   (res_ch)
    );

    nps_sched_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_job        (job_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, except in the steady stretch
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready <= steady || ($urandom_range(99) >= 26);
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one job beat after an optional idle gap; return once it is taken
    task automatic push_job(input logic [ARR_W-1:0] arrival, input logic [BUR_W-1:0] burst,
                            input logic [PRI_W-1:0] prio, input logic end_of_set);
        while (!steady && $urandom_range(99) < 26) begin
            job_ch.valid <= 1'b0;
            @(negedge clk);
        end
        job_ch.valid          <= 1'b1;
        job_ch.arrival_time   <= arrival;
        job_ch.burst_time     <= burst;
        job_ch.priority_level <= prio;
        job_ch.last_process   <= end_of_set;
        @(posedge clk);
        while (!job_ch.ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    initial begin
        int               set_size;
        int               sel;
        int               arr_mode;
        int               bur_mode;
        int               pri_mode;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        logic [PRI_W-1:0] pri;

        job_ch.valid          = 1'b0;
        job_ch.arrival_time   = '0;
        job_ch.burst_time     = '0;
        job_ch.priority_level = '0;
        job_ch.last_process   = 1'b0;
        rst_n                 = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single job with every field at its maximum
        push_job('1, '1, '1, 1'b1);
        // single job with every field zero: completes the moment it starts
        push_job('0, '0, '0, 1'b1);
        // idle gaps between arrivals, a zero burst, and a priority tie
        push_job(16'd100, 16'd5, 8'd7, 1'b0);
        push_job(16'd0, 16'd0, 8'd255, 1'b0);
        push_job(16'd5000, 16'd3, 8'd7, 1'b0);
        push_job(16'd5000, 16'd9, 8'd7, 1'b1);
        // full table of jobs with maximal arrival and burst, then one extra beat that is dropped
        for (int k = 0; k < MAX_PROCS; k++)
            push_job('1, '1, PRI_W'(k % 3), 1'b0);
        push_job(16'd0, 16'd1, 8'd0, 1'b1);

        // random sets, mostly small, a few full or overflowing
        while (items_sent < TOTAL_ITEMS) begin
            steady <= (items_sent >= 50 && items_sent < 75);
            sel = $urandom_range(99);
            if (sel < 65)
                set_size = $urandom_range(6, 1);
            else if (sel < 85)
                set_size = $urandom_range(15, 7);
            else if (sel < 93)
                set_size = MAX_PROCS;
            else
                set_size = $urandom_range(MAX_PROCS + 3, MAX_PROCS + 1);
            arr_mode = $urandom_range(2);
            bur_mode = $urandom_range(1);
            pri_mode = $urandom_range(1);
            for (int k = 0; k < set_size; k++) begin
                case (arr_mode)
                    0: arr = ARR_W'($urandom_range(40));
                    1: arr = ARR_W'($urandom);
                    default: arr = ARR_W'(65535 - $urandom_range(40));
                endcase
                bur = (bur_mode == 0) ? BUR_W'($urandom_range(12)) : BUR_W'($urandom);
                pri = (pri_mode == 0) ? PRI_W'($urandom_range(3)) : PRI_W'($urandom);
                push_job(arr, bur, pri, k == set_size - 1);
            end
        end
        job_ch.valid <= 1'b0;

        // drain outstanding results, then let the block settle
        while (pending_results != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
